/* rtl/core/bfd_pkg.sv */
// Box filter downscaler: shared widths, register indexes, reset values
// and the control word that travels from the raster tracker to the lanes.
// No dependencies.
`default_nettype none

package bfd_pkg;

  // Field and state widths
  localparam int SAMPLE_W   = 8;
  localparam int POS_W      = 11;
  localparam int RUN_W      = 12;
  localparam int COL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Parameter defaults
  localparam int DEF_SCALE           = 15;
  localparam int DEF_MAX_OUT_COLUMNS = 128;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_COMPONENTS = 2'd2;

  // Configuration reset values
  localparam logic [POS_W-1:0] IN_WIDTH_RST  = 11'd720;
  localparam logic [POS_W-1:0] IN_HEIGHT_RST = 11'd576;

  // Per-word control: what the lanes do with the current sample
  typedef struct packed {
    logic             v;         // sample lies inside a whole square below the column cap
    logic             blk_end;   // last column of its square
    logic             line_end;  // last sample of the line
    logic             use_col;   // add the stored column sum
    logic             wr;        // store the square-row sum
    logic             is_out;    // bottom-right sample: emit a pixel
    logic             last;      // final pixel of the frame
    logic [POS_W-1:0] ox;        // output column
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/core/bfd_in_if.sv */
// Input channel of the box filter downscaler: one sample word per handshake.
// Depends on bfd_pkg.
`default_nettype none

interface bfd_in_if import bfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_a;
  logic [SAMPLE_W-1:0] sample_b;

  modport source (output valid, output sample_a, output sample_b, input ready);
  modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

`default_nettype wire

/* rtl/core/bfd_out_if.sv */
// Output channel of the box filter downscaler: one averaged pixel word.
// Depends on bfd_pkg.
`default_nettype none

interface bfd_out_if import bfd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] avg_a;
  logic [SAMPLE_W-1:0] avg_b;
  logic                frame_last;

  modport source (output valid, output avg_a, output avg_b, output frame_last,
                  input ready);
  modport sink   (input valid, input avg_a, input avg_b, input frame_last,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/bfd_ctrl.sv */
// Raster position tracker: follows line and square position of each sample
// and derives the control word shared by both lanes. Depends on bfd_pkg.
`default_nettype none

module bfd_ctrl import bfd_pkg::*; #(
  parameter int SCALE           = DEF_SCALE,
  parameter int MAX_OUT_COLUMNS = DEF_MAX_OUT_COLUMNS
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             acc_i,
  input  wire logic [POS_W-1:0] in_width_i,
  input  wire logic [POS_W-1:0] in_height_i,
  output ctl_t                  cur_o,
  output ctl_t                  s1_o
);

  localparam int BLK_W = $clog2(SCALE);
  localparam logic [BLK_W-1:0] BlkLast  = BLK_W'(SCALE - 1);
  localparam logic [POS_W:0]   BlkSpan  = (POS_W+1)'(SCALE);
  localparam logic [POS_W:0]   BlkSpan2 = (POS_W+1)'(2 * SCALE);
  localparam logic [POS_W-1:0] ColLimit = POS_W'(MAX_OUT_COLUMNS);
  localparam logic [POS_W-1:0] ColLast  = POS_W'(MAX_OUT_COLUMNS - 1);

  logic [POS_W-1:0] x_pos_q, x_pos_d, y_pos_q, y_pos_d, ox_q, ox_d;
  logic [BLK_W-1:0] x_blk_q, x_blk_d, y_blk_q, y_blk_d;
  ctl_t             s1_q, s1_d;

  logic [POS_W:0]   x_base, y_base, width_ext, height_ext;
  logic             x_fit, y_fit, x_no_next, y_no_next, frame_end;
  logic             x_blk_end, y_blk_end;

  // Square geometry of the current sample
  always_comb begin
    width_ext  = {1'b0, in_width_i};
    height_ext = {1'b0, in_height_i};
    x_base     = {1'b0, x_pos_q} - {{(POS_W+1-BLK_W){1'b0}}, x_blk_q};
    y_base     = {1'b0, y_pos_q} - {{(POS_W+1-BLK_W){1'b0}}, y_blk_q};
    x_fit      = (x_base + BlkSpan) <= width_ext;
    y_fit      = (y_base + BlkSpan) <= height_ext;
    x_no_next  = (x_base + BlkSpan2) > width_ext;
    y_no_next  = (y_base + BlkSpan2) > height_ext;
    x_blk_end  = x_blk_q == BlkLast;
    y_blk_end  = y_blk_q == BlkLast;
    frame_end  = ({1'b0, y_pos_q} + 1'b1) >= height_ext;

    cur_o.v        = x_fit && y_fit && (ox_q < ColLimit);
    cur_o.blk_end  = x_blk_end;
    cur_o.line_end = ({1'b0, x_pos_q} + 1'b1) >= width_ext;
    cur_o.use_col  = y_blk_q != '0;
    cur_o.wr       = x_blk_end && !y_blk_end;
    cur_o.is_out   = x_blk_end && y_blk_end;
    cur_o.last     = cur_o.v && x_blk_end && y_blk_end && y_no_next &&
                     (x_no_next || (ox_q == ColLast));
    cur_o.ox       = ox_q;
  end

  // Advance the raster position
  always_comb begin
    x_pos_d = x_pos_q;
    y_pos_d = y_pos_q;
    x_blk_d = x_blk_q;
    y_blk_d = y_blk_q;
    ox_d    = ox_q;
    if (acc_i) begin
      if (cur_o.line_end) begin
        x_pos_d = '0;
        x_blk_d = '0;
        ox_d    = '0;
        if (frame_end) begin
          y_pos_d = '0;
          y_blk_d = '0;
        end else begin
          y_pos_d = y_pos_q + 1'b1;
          y_blk_d = y_blk_end ? '0 : y_blk_q + 1'b1;
        end
      end else begin
        x_pos_d = x_pos_q + 1'b1;
        x_blk_d = x_blk_end ? '0 : x_blk_q + 1'b1;
        ox_d    = x_blk_end ? ox_q + 1'b1 : ox_q;
      end
    end
  end

  // Stage-1 control: only square-end samples do work there
  always_comb begin
    s1_d   = s1_q;
    if (en_i) begin
      s1_d   = cur_o;
      s1_d.v = acc_i && cur_o.v && cur_o.blk_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_pos_q <= '0;
      y_pos_q <= '0;
      x_blk_q <= '0;
      y_blk_q <= '0;
      ox_q    <= '0;
      s1_q    <= '0;
    end else begin
      x_pos_q <= x_pos_d;
      y_pos_q <= y_pos_d;
      x_blk_q <= x_blk_d;
      y_blk_q <= y_blk_d;
      ox_q    <= ox_d;
      s1_q    <= s1_d;
    end
  end

  assign s1_o = s1_q;

  // Position inside the square never passes the square size
  a_blk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_blk_q <= BlkLast) && (y_blk_q <= BlkLast))
    else $error("square position out of range");

  // Frame end flag only on an emitted pixel
  a_last_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_o.last |-> (cur_o.is_out && cur_o.v))
    else $error("frame_last on a sample that emits nothing");

  // A square-end sample either stores a row sum or emits, never both
  a_wr_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.v |-> (s1_q.wr != s1_q.is_out))
    else $error("stage-1 store and emit overlap");

endmodule

`default_nettype wire

/* rtl/core/bfd_lane.sv */
// One component lane: running square-row sum, column-sum RAM and the
// reciprocal multiply that divides by the square area. Depends on bfd_pkg.
`default_nettype none

module bfd_lane import bfd_pkg::*; #(
  parameter int SCALE           = DEF_SCALE,
  parameter int MAX_OUT_COLUMNS = DEF_MAX_OUT_COLUMNS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                acc_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire ctl_t                cur_i,
  input  wire ctl_t                s1_i,
  output logic [SAMPLE_W-1:0]      quo_o
);

  localparam int DIV     = SCALE * SCALE;
  localparam int SHIFT   = COL_W + $clog2(DIV);
  localparam int RECIP   = ((2 ** SHIFT) + DIV - 1) / DIV;
  localparam int RECIP_W = COL_W + 1;
  localparam int PROD_W  = COL_W + RECIP_W;
  localparam int ADDR_W  = $clog2(MAX_OUT_COLUMNS);
  localparam logic [RECIP_W-1:0] RecipC = RECIP_W'(RECIP);

  logic [RUN_W-1:0]  run_q, run_d, run_plus, s1_sum_q;
  logic [COL_W-1:0]  rd_q, total;
  logic [COL_W-1:0]  col_sum_mem [MAX_OUT_COLUMNS];
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_go;

  // Running sum of the current square row
  assign run_plus = run_q + RUN_W'(sample_i);

  always_comb begin
    run_d = run_q;
    if (acc_i) begin
      if (cur_i.line_end || (cur_i.v && cur_i.blk_end)) begin
        run_d = '0;
      end else if (cur_i.v) begin
        run_d = run_plus;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

  // Stage 1: add the stored column sum to this square row
  assign total   = {{(COL_W-RUN_W){1'b0}}, s1_sum_q} + (s1_i.use_col ? rd_q : '0);
  assign rd_addr = cur_i.ox[ADDR_W-1:0];
  assign wr_addr = s1_i.ox[ADDR_W-1:0];
  assign wr_go   = en_i && s1_i.v && s1_i.wr;

  // Column-sum RAM: read on accept, write back from stage 1
  always_ff @(posedge clk_i) begin
    if (wr_go) begin
      col_sum_mem[wr_addr] <= total;
    end
    if (acc_i) begin
      s1_sum_q <= run_plus;
      rd_q     <= (wr_go && (wr_addr == rd_addr)) ? total : col_sum_mem[rd_addr];
    end
  end

  // Stage 2: divide by the square area through a reciprocal multiply
  assign prod_d = PROD_W'(total) * PROD_W'(RecipC);

  always_ff @(posedge clk_i) begin
    if (en_i && s1_i.v && s1_i.is_out) begin
      prod_q <= prod_d;
    end
  end

  assign quo_o = prod_q[SHIFT +: SAMPLE_W];

endmodule

`default_nettype wire

/* rtl/core/bfd_merge.sv */
// Merging stage: joins the two lane quotients and the frame flag into one
// output word held in the output register. Depends on bfd_pkg, bfd_out_if.
`default_nettype none

module bfd_merge import bfd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ctl_t                s1_i,
  input  wire logic [SAMPLE_W-1:0] quo_a_i,
  input  wire logic [SAMPLE_W-1:0] quo_b_i,
  input  wire logic                two_comp_i,
  output logic                     en_o,
  bfd_out_if.source                out_if
);

  logic                s2_v_q, s2_last_q, out_v_q, last_q;
  logic [SAMPLE_W-1:0] avg_a_q, avg_b_q;

  // Advance the whole pipe whenever the output register can take a word
  assign en_o = !out_v_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_o) begin
      s2_v_q  <= s1_i.v && s1_i.is_out;
      out_v_q <= s2_v_q;
    end
  end

  // Combine lane results; drop the second component for luma
  always_ff @(posedge clk_i) begin
    if (en_o) begin
      s2_last_q <= s1_i.last;
      last_q    <= s2_last_q;
      avg_a_q   <= quo_a_i;
      avg_b_q   <= two_comp_i ? quo_b_i : '0;
    end
  end

  assign out_if.valid      = out_v_q;
  assign out_if.avg_a      = avg_a_q;
  assign out_if.avg_b      = avg_b_q;
  assign out_if.frame_last = last_q;

endmodule

`default_nettype wire

/* rtl/core/box_filter_downscaler_core.sv */
// Box filter downscaler, top level: configuration registers, raster tracker,
// two component lanes and the merging output stage. Depends on bfd_pkg,
// bfd_in_if, bfd_out_if, bfd_ctrl, bfd_lane, bfd_merge.
`default_nettype none

// Takes one sample word per clock in raster order and emits the truncated
// mean of every SCALE x SCALE square on its bottom-right sample; leftover
// columns and lines, and columns at or beyond MAX_OUT_COLUMNS, are consumed
// silently. Throughput is one word per cycle; input ready drops only while
// the output register holds a word that is not taken. After its last sample
// a pixel passes the RAM read, the column-sum add with write-back, the
// reciprocal multiply and then the output register. Each lane keeps its column
// sums in a MAX_OUT_COLUMNS-entry RAM with one read and one write port; no
// clearing pass is needed since every entry is written before it is used.
// Write the size registers only with the pipe empty.
module box_filter_downscaler_core import bfd_pkg::*; #(
  parameter int SCALE           = DEF_SCALE,
  parameter int MAX_OUT_COLUMNS = DEF_MAX_OUT_COLUMNS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  bfd_in_if.sink                     in_if,
  bfd_out_if.source                  out_if
);

  logic [POS_W-1:0]    in_width_q, in_height_q;
  logic                two_comp_q;
  logic                en, acc;
  ctl_t                cur, s1;
  logic [SAMPLE_W-1:0] quo_a, quo_b;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q  <= IN_WIDTH_RST;
      in_height_q <= IN_HEIGHT_RST;
      two_comp_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IN_WIDTH:       in_width_q  <= cfg_data_i;
        CFG_IN_HEIGHT:      in_height_q <= cfg_data_i;
        CFG_TWO_COMPONENTS: two_comp_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = en;
  assign acc         = in_if.valid && en;

  bfd_ctrl #(
    .SCALE           (SCALE),
    .MAX_OUT_COLUMNS (MAX_OUT_COLUMNS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .acc_i       (acc),
    .in_width_i  (in_width_q),
    .in_height_i (in_height_q),
    .cur_o       (cur),
    .s1_o        (s1)
  );

  bfd_lane #(
    .SCALE           (SCALE),
    .MAX_OUT_COLUMNS (MAX_OUT_COLUMNS)
  ) u_lane_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .acc_i    (acc),
    .sample_i (in_if.sample_a),
    .cur_i    (cur),
    .s1_i     (s1),
    .quo_o    (quo_a)
  );

  bfd_lane #(
    .SCALE           (SCALE),
    .MAX_OUT_COLUMNS (MAX_OUT_COLUMNS)
  ) u_lane_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .acc_i    (acc),
    .sample_i (in_if.sample_b),
    .cur_i    (cur),
    .s1_i     (s1),
    .quo_o    (quo_b)
  );

  bfd_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_i       (s1),
    .quo_a_i    (quo_a),
    .quo_b_i    (quo_b),
    .two_comp_i (two_comp_q),
    .en_o       (en),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire

/* tb/sv/bfd_pixel_checker.sv */
`timescale 1ns / 100ps
// Pixel checker for the box filter downscaler: tracks the raster position and
// the column sums, predicts every averaged pixel and compares the output words.
// Depends on bfd_pkg, bfd_in_if and bfd_out_if.

module bfd_pixel_checker import bfd_pkg::*; #(
  parameter int SCALE           = DEF_SCALE,
  parameter int MAX_OUT_COLUMNS = DEF_MAX_OUT_COLUMNS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  bfd_in_if                     in_mon,
  bfd_out_if                    out_mon,
  output int                    fail_cnt_o,
  output int                    pend_cnt_o,
  output int                    pix_cnt_o
);

  localparam int AREA = SCALE * SCALE;

  typedef struct packed {
    logic [SAMPLE_W-1:0] avg_a;
    logic [SAMPLE_W-1:0] avg_b;
    logic                frame_last;
  } pixel_t;

  pixel_t pending_pixels[$];
  pixel_t want_pix;

  // Shadow of the size registers
  logic [POS_W-1:0] width_q;
  logic [POS_W-1:0] height_q;
  logic             two_q;

  // Column sums of the finished square rows and sums of the current one
  logic [COL_W-1:0] colsum_a [MAX_OUT_COLUMNS];
  logic [COL_W-1:0] colsum_b [MAX_OUT_COLUMNS];
  logic [RUN_W-1:0] rowsum_a;
  logic [RUN_W-1:0] rowsum_b;

  // Raster position of the next sample and position inside its square
  logic [POS_W-1:0] xpos;
  logic [POS_W-1:0] ypos;
  logic [3:0]       xblk;
  logic [3:0]       yblk;

  int fails;
  int seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] bfd_pixel_checker: %s", $time, msg);
    fails++;
  endtask

  // Fold one accepted sample word into the sums; queue a pixel on the
  // bottom-right sample of a square, then advance the raster position.
  task automatic accumulate_sample(input logic [SAMPLE_W-1:0] a,
                                   input logic [SAMPLE_W-1:0] b);
    int unsigned      cols;
    int unsigned      rows;
    int unsigned      ox;
    logic [COL_W-1:0] tot_a;
    logic [COL_W-1:0] tot_b;
    pixel_t           pix;
    cols = 32'(width_q) / SCALE;
    rows = 32'(height_q) / SCALE;
    ox   = 32'(xpos) / SCALE;
    if (cols > MAX_OUT_COLUMNS) cols = MAX_OUT_COLUMNS;

    if (32'(xpos) < cols * SCALE && 32'(ypos) < rows * SCALE && ox < MAX_OUT_COLUMNS) begin
      rowsum_a = rowsum_a + RUN_W'(a);
      rowsum_b = rowsum_b + RUN_W'(b);
      if (32'(xblk) == SCALE - 1) begin
        tot_a = COL_W'(rowsum_a);
        tot_b = COL_W'(rowsum_b);
        if (yblk != '0) begin
          tot_a = tot_a + colsum_a[ox];
          tot_b = tot_b + colsum_b[ox];
        end
        if (32'(yblk) == SCALE - 1) begin
          pix.avg_a      = SAMPLE_W'(tot_a / COL_W'(AREA));
          pix.avg_b      = two_q ? SAMPLE_W'(tot_b / COL_W'(AREA)) : '0;
          pix.frame_last = (32'(ypos) == rows * SCALE - 1) && (ox == cols - 1);
          pending_pixels.push_back(pix);
        end else begin
          colsum_a[ox] = tot_a;
          colsum_b[ox] = tot_b;
        end
        rowsum_a = '0;
        rowsum_b = '0;
      end
    end

    // Advance; a width or height of 0 or 1 ends the line or frame every word
    if (32'(xpos) + 1 >= 32'(width_q)) begin
      xpos     = '0;
      xblk     = '0;
      rowsum_a = '0;
      rowsum_b = '0;
      if (32'(ypos) + 1 >= 32'(height_q)) begin
        ypos = '0;
        yblk = '0;
      end else begin
        ypos = ypos + 1'b1;
        yblk = (32'(yblk) + 1 >= SCALE) ? '0 : yblk + 1'b1;
      end
    end else begin
      xpos = xpos + 1'b1;
      xblk = (32'(xblk) + 1 >= SCALE) ? '0 : xblk + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = IN_WIDTH_RST;
      height_q = IN_HEIGHT_RST;
      two_q    = 1'b0;
      for (int i = 0; i < MAX_OUT_COLUMNS; i++) begin
        colsum_a[i] = '0;
        colsum_b[i] = '0;
      end
      rowsum_a = '0;
      rowsum_b = '0;
      xpos     = '0;
      ypos     = '0;
      xblk     = '0;
      yblk     = '0;
      pending_pixels.delete();
      fail_cnt_o <= fails;
      pend_cnt_o <= 0;
      pix_cnt_o  <= seen;
    end else begin
      // Mirror register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IN_WIDTH:       width_q  = cfg_data_i;
          CFG_IN_HEIGHT:      height_q = cfg_data_i;
          CFG_TWO_COMPONENTS: two_q    = cfg_data_i[0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        accumulate_sample(in_mon.sample_a, in_mon.sample_b);
      end

      // Compare each output word with the oldest predicted pixel
      if (out_mon.valid && out_mon.ready) begin
        seen++;
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %0d arrived with none predicted", seen));
        end else begin
          want_pix = pending_pixels.pop_front();
          if (out_mon.avg_a !== want_pix.avg_a)
            report_mismatch($sformatf("pixel %0d avg_a got %0d, want %0d",
                                      seen, out_mon.avg_a, want_pix.avg_a));
          if (out_mon.avg_b !== want_pix.avg_b)
            report_mismatch($sformatf("pixel %0d avg_b got %0d, want %0d",
                                      seen, out_mon.avg_b, want_pix.avg_b));
          if (out_mon.frame_last !== want_pix.frame_last)
            report_mismatch($sformatf("pixel %0d frame_last got %0b, want %0b",
                                      seen, out_mon.frame_last, want_pix.frame_last));
        end
      end

      fail_cnt_o <= fails;
      pend_cnt_o <= pending_pixels.size();
      pix_cnt_o  <= seen;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the box filter downscaler testbench: clock, reset, register writes,
// sample stimulus and receiver stalls; verdict from bfd_pixel_checker.
// Depends on bfd_pkg, bfd_in_if, bfd_out_if and box_filter_downscaler_core.

module tb_top;
  import bfd_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;
  typedef enum int {FILL_UNIFORM, FILL_EXTREME, FILL_HIGH, FILL_MAX, FILL_ZERO} fill_e;

  localparam int     SCALE         = DEF_SCALE;
  localparam int     RAND_WORDS    = 1400;
  localparam int     RAND_PIXELS   = 48;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     SETTLE_CYCLES = 12;
  localparam longint LIMIT_CYCLES  = 3_000_000;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bfd_in_if  pix_in ();
  bfd_out_if pix_out ();

  int     fail_cnt;
  int     pend_cnt;
  int     pix_cnt;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  logic   hold_req       = 1'b0;
  int     words_sent     = 0;
  int     phases_run     = 0;
  int     cur_w          = 0;
  int     cur_h          = 0;
  int     tx             = 0;
  int     ty             = 0;
  longint cycles         = 0;

  box_filter_downscaler_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (pix_in),
    .out_if     (pix_out)
  );

  bfd_pixel_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_mon     (pix_in),
    .out_mon    (pix_out),
    .fail_cnt_o (fail_cnt),
    .pend_cnt_o (pend_cnt),
    .pix_cnt_o  (pix_cnt)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Drive output ready: random stalls, plus a long hold on each hold_req toggle
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left      = 0;
    hold_seen      = 1'b0;
    pix_out.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pix_out.ready <= 1'b0;
      end else begin
        pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic configure(input int w, input int h, input bit two);
    write_reg(CFG_IN_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_IN_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_TWO_COMPONENTS, CFG_DATA_W'(two));
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 88; recv_stall_pct <= 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct <= 88; end
      IDLE_BOTH: begin send_idle_pct = 35; recv_stall_pct <= 35; end
      default:   begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
    endcase
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input fill_e fill);
    case (fill)
      FILL_EXTREME: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      FILL_HIGH:    return SAMPLE_W'($urandom_range(255, 224));
      FILL_MAX:     return 8'hFF;
      FILL_ZERO:    return 8'h00;
      default:      return SAMPLE_W'($urandom_range(255));
    endcase
  endfunction

  // Offer one word after a random gap, hold it until accepted, track the raster
  task automatic push_sample(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid    <= 1'b1;
    pix_in.sample_a <= a;
    pix_in.sample_b <= b;
    do @(posedge clk_i); while (!pix_in.ready);
    words_sent++;
    if (tx + 1 >= cur_w) begin
      tx = 0;
      ty = (ty + 1 >= cur_h) ? 0 : ty + 1;
    end else begin
      tx++;
    end
  endtask

  // Send words until the raster wraps; optionally start a long receiver hold
  // just before the first square row completes
  task automatic send_frame(input fill_e fill, input bit squeeze);
    do begin
      if (squeeze && tx == 0 && ty == SCALE - 1) begin
        hold_req <= ~hold_req;
        squeeze = 1'b0;
      end
      push_sample(pick_sample(fill), pick_sample(fill));
    end while (tx != 0 || ty != 0);
  endtask

  // Drop valid and wait until every predicted pixel is out and the pipe is quiet
  task automatic wait_drained();
    pix_in.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int w, input int h, input bit two, input int frames,
                           input fill_e fill, input idle_mode_e mode, input bit squeeze);
    wait_drained();
    configure(w, h, two);
    set_idle(mode);
    phases_run++;
    repeat (frames) begin
      send_frame(fill, squeeze);
      squeeze = 1'b0;
    end
  endtask

  // Resize at the start of the third square row, with the pipe drained first
  task automatic resize_mid_frame(input int w0, input int h0, input int w1, input int h1);
    run_phase(w0, h0, 1'b1, 0, FILL_UNIFORM, IDLE_NONE, 1'b0);
    do push_sample(pick_sample(FILL_UNIFORM), pick_sample(FILL_UNIFORM));
    while (tx != 0 || ty != 2 * SCALE);
    wait_drained();
    configure(w1, h1, 1'b1);
    send_frame(FILL_UNIFORM, 1'b0);
  endtask

  initial begin
    int         w;
    int         h;
    int         sel;
    fill_e      fill;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_IN_WIDTH;
    cfg_data        = '0;
    pix_in.valid    = 1'b0;
    pix_in.sample_a = '0;
    pix_in.sample_b = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Degenerate sizes: every word ends a line, or every line ends a frame
    run_phase(0, 0, 1'b1, 0, FILL_UNIFORM, IDLE_NONE, 1'b0);
    push_sample(8'h00, 8'hFF);
    push_sample(8'hFF, 8'h00);
    push_sample(8'hAA, 8'h55);
    push_sample(8'h55, 8'hAA);
    run_phase(1, 1, 1'b0, 0, FILL_UNIFORM, IDLE_NONE, 1'b0);
    push_sample(8'hFF, 8'hFF);
    push_sample(8'h00, 8'h00);
    push_sample(8'h80, 8'h01);
    run_phase(0, 2, 1'b1, 2, FILL_EXTREME, IDLE_NONE, 1'b0);
    run_phase(14, 1, 1'b1, 1, FILL_EXTREME, IDLE_NONE, 1'b0);

    // Single squares at full scale, at zero, and luma with Cb content present
    run_phase(15, 15, 1'b1, 1, FILL_MAX, IDLE_NONE, 1'b0);
    run_phase(15, 15, 1'b1, 1, FILL_ZERO, IDLE_RECV, 1'b0);
    run_phase(15, 15, 1'b0, 1, FILL_UNIFORM, IDLE_SEND, 1'b0);

    // Random sizes, mostly with whole squares, cycling through the idle modes
    while (words_sent < RAND_WORDS || pix_cnt < RAND_PIXELS) begin
      sel = $urandom_range(5);
      if (sel == 0) begin
        w = $urandom_range(20);
        h = $urandom_range(14);
      end else if (sel == 1) begin
        w = $urandom_range(14);
        h = $urandom_range(20);
      end else begin
        w = $urandom_range(64, 15);
        h = $urandom_range(47, 15);
      end
      case ($urandom_range(5))
        0:       fill = FILL_EXTREME;
        1:       fill = FILL_HIGH;
        default: fill = FILL_UNIFORM;
      endcase
      run_phase(w, h, 1'($urandom_range(1)), (sel < 2) ? 2 : 1, fill,
                idle_mode_e'(phases_run % 4), 1'b0);
    end

    // Fill the pipe behind a long receiver hold
    run_phase(90, 30, 1'b1, 1, FILL_UNIFORM, IDLE_NONE, 1'b1);

    // Resize in mid-frame: wider lines, then a height that ends the frame at once
    resize_mid_frame(45, 60, 75, 45);
    resize_mid_frame(45, 60, 45, 20);

    // Size extremes: column cap, widest nominal line, tallest frame
    run_phase(2047, 15, 1'b1, 1, FILL_HIGH, IDLE_NONE, 1'b0);
    run_phase(1920, 15, 1'b0, 1, FILL_UNIFORM, IDLE_BOTH, 1'b0);
    run_phase(15, 2047, 1'b1, 1, FILL_UNIFORM, IDLE_NONE, 1'b0);

    wait_drained();
    $display("tb_top: %0d sample words over %0d register settings, %0d pixels compared",
             words_sent, phases_run, pix_cnt);
    $display("tb_top: luma and chroma, tiny planes, column cap, mid-frame resize, long stall");
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* box_filter_downscaler_core.f */
rtl/core/bfd_pkg.sv
rtl/core/bfd_in_if.sv
rtl/core/bfd_out_if.sv
rtl/core/bfd_ctrl.sv
rtl/core/bfd_lane.sv
rtl/core/bfd_merge.sv
rtl/core/box_filter_downscaler_core.sv
tb/sv/bfd_pixel_checker.sv
tb/sv/tb_top.sv
